[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers included by robust_survival_weight.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication under a synchronous reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

[rtl/rsw_pkg.sv]
// ----------------------------------------------------------------------------
// rsw_pkg
// Types and constants of the survival weight pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsw_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int DATA_WIDTH    = 32;
   localparam int PROD_WIDTH    = 2 * DATA_WIDTH;

   // Exponential: integer part of p/M below 2^EXP_INT_BITS, Q31 series
   localparam int EXP_INT_BITS  = 5;
   localparam int EXP_TERMS     = 12;
   localparam int EXP_SQUARINGS = 5;
   localparam int Q31_BITS      = 31;
   localparam int S_WIDTH       = Q31_BITS + 1;
   localparam int G_WIDTH       = Q31_BITS;
   localparam int G_SHIFT       = Q31_BITS - FRAC_BITS - EXP_INT_BITS;
   localparam int RECIP_SHIFT   = 33;
   localparam int RECIP_WIDTH   = RECIP_SHIFT + 1;

   localparam int DIV_STEPS     = EXP_INT_BITS + FRAC_BITS;
   localparam int REM_WIDTH     = DATA_WIDTH + 1;

   localparam int PIPE_LATENCY  = 3 + DIV_STEPS + 1 + 3 * EXP_TERMS + EXP_SQUARINGS + 1;

   localparam int CSR_INDEX_WIDTH = 1;

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [S_WIDTH-1:0]    s_type;

   typedef enum logic [1:0] {
      MODE_IDENTITY    = 2'd0,
      MODE_LINEAR      = 2'd1,
      MODE_QUADRATIC   = 2'd2,
      MODE_EXPONENTIAL = 2'd3
   } mode_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WEIGHT_MODE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIMIT_M     = 1'b1;

   localparam data_type ONE_Q         = data_type'(1) << FRAC_BITS;
   localparam data_type LIMIT_M_RESET = ONE_Q;
   localparam s_type    S_ONE         = s_type'(1) << Q31_BITS;

   typedef struct packed {
      mode_type               mode;
      logic                   kill;
      data_type               lin;
      logic [FRAC_BITS-1:0]   quad;
   } side_type;

   typedef struct packed {
      side_type               side;
      logic [G_WIDTH-1:0]     g;
   } carry_type;

endpackage

[rtl/robust_survival_weight.sv]
// ----------------------------------------------------------------------------
// robust_survival_weight
// Every mode passes through the same stages from start to rsp_valid.
// Throughput: one item per cycle; busy stays low, results cannot be held off.
// Depth is set by the 21-step quotient chain and the 12-term exp series.
// Reset clears the valid bits and loads weight_mode 0, limit_m 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module robust_survival_weight (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  rsw_pkg::data_type                      req_event_time,
   input  rsw_pkg::data_type                      req_risk_factor,
   output logic                                   rsp_valid,
   output rsw_pkg::data_type                      rsp_weight,
   input  logic                                   csr_write_enable,
   input  logic [rsw_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  rsw_pkg::data_type                      csr_wdata
);

   // ---------------- configuration ----------------
   rsw_pkg::mode_type mode_ff;
   rsw_pkg::data_type limit_m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= rsw_pkg::MODE_IDENTITY;
         limit_m_ff <= rsw_pkg::LIMIT_M_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rsw_pkg::CSR_WEIGHT_MODE: mode_ff    <= rsw_pkg::mode_type'(csr_wdata[1:0]);
            rsw_pkg::CSR_LIMIT_M:     limit_m_ff <= csr_wdata;
            default:                  mode_ff    <= mode_ff;
         endcase
      end
   end

   assign busy = 1'b0;

   // ---------------- stage 1: raw product ----------------
   logic                                  v1_ff;
   rsw_pkg::mode_type                     mode1_ff;
   logic [rsw_pkg::PROD_WIDTH-1:0]        prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
      mode1_ff <= mode_ff;
      prod_ff  <= rsw_pkg::PROD_WIDTH'(req_event_time) * rsw_pkg::PROD_WIDTH'(req_risk_factor);
   end

   // ---------------- stage 2: scale and saturate ----------------
   logic              v2_ff;
   rsw_pkg::mode_type mode2_ff;
   rsw_pkg::data_type p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      mode2_ff <= mode1_ff;
      if (prod_ff[rsw_pkg::PROD_WIDTH-1:rsw_pkg::DATA_WIDTH+rsw_pkg::FRAC_BITS] != '0) begin
         p_ff <= '1;
      end else begin
         p_ff <= prod_ff[rsw_pkg::DATA_WIDTH+rsw_pkg::FRAC_BITS-1:rsw_pkg::FRAC_BITS];
      end
   end

   // ---------------- stage 3: linear weight, divider operand ----------------
   logic                                  dv_ff   [0:rsw_pkg::DIV_STEPS];
   rsw_pkg::side_type                     dside_ff[0:rsw_pkg::DIV_STEPS];
   logic [rsw_pkg::REM_WIDTH-1:0]         rem_ff  [0:rsw_pkg::DIV_STEPS];
   logic [rsw_pkg::DIV_STEPS-1:0]         quo_ff  [0:rsw_pkg::DIV_STEPS];

   rsw_pkg::data_type lin_in;
   logic              kill_in;

   always_comb begin
      lin_in  = (limit_m_ff > p_ff) ? limit_m_ff - p_ff : '0;
      // drop items under a zero limit, and exp items whose p/M integer part overflows the series range
      kill_in = (limit_m_ff == '0) ||
                ((mode2_ff == rsw_pkg::MODE_EXPONENTIAL) &&
                 ({{rsw_pkg::EXP_INT_BITS{1'b0}}, p_ff} >=
                  {limit_m_ff, {rsw_pkg::EXP_INT_BITS{1'b0}}}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= v2_ff;
      end
      dside_ff[0].mode <= mode2_ff;
      dside_ff[0].kill <= kill_in;
      dside_ff[0].lin  <= lin_in;
      dside_ff[0].quad <= '0;
      rem_ff[0]        <= rsw_pkg::REM_WIDTH'((mode2_ff == rsw_pkg::MODE_QUADRATIC) ?
                                              lin_in : p_ff);
      quo_ff[0]        <= '0;
   end

   // ---------------- restoring divider, one quotient bit per stage ----------------
   for (genvar j = 0; j < rsw_pkg::DIV_STEPS; j++) begin : g_div
      logic                          ge;
      logic [rsw_pkg::REM_WIDTH-1:0] rem_next;

      if (j < rsw_pkg::EXP_INT_BITS) begin : g_int
         localparam int SH = rsw_pkg::EXP_INT_BITS - 1 - j;
         localparam int WW = rsw_pkg::REM_WIDTH + rsw_pkg::EXP_INT_BITS;
         logic [WW-1:0] rw;
         logic [WW-1:0] mw;
         always_comb begin
            rw       = WW'(rem_ff[j]);
            mw       = WW'(limit_m_ff) << SH;
            // hold the quadratic difference whole: its quotient is fraction only,
            // so a difference equal to M yields all ones
            ge       = (rw >= mw) && (dside_ff[j].mode != rsw_pkg::MODE_QUADRATIC);
            rem_next = ge ? rsw_pkg::REM_WIDTH'(rw - mw) : rem_ff[j];
         end
      end else begin : g_frac
         logic [rsw_pkg::REM_WIDTH-1:0] r2;
         logic [rsw_pkg::REM_WIDTH-1:0] mw;
         always_comb begin
            r2       = {rem_ff[j][rsw_pkg::REM_WIDTH-2:0], 1'b0};
            mw       = rsw_pkg::REM_WIDTH'(limit_m_ff);
            ge       = r2 >= mw;
            rem_next = ge ? r2 - mw : r2;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else begin
            dv_ff[j+1] <= dv_ff[j];
         end
         dside_ff[j+1] <= dside_ff[j];
         rem_ff[j+1]   <= rem_next;
         quo_ff[j+1]   <= {quo_ff[j][rsw_pkg::DIV_STEPS-2:0], ge};
      end
   end

   // ---------------- quadratic square, series setup ----------------
   localparam int QSQ_WIDTH = 2 * rsw_pkg::FRAC_BITS;

   logic                 hv_ff[0:rsw_pkg::EXP_TERMS];
   rsw_pkg::carry_type   hc_ff[0:rsw_pkg::EXP_TERMS];
   rsw_pkg::s_type       hs_ff[0:rsw_pkg::EXP_TERMS];

   logic [QSQ_WIDTH-1:0] qsq;

   always_comb begin
      qsq = QSQ_WIDTH'(quo_ff[rsw_pkg::DIV_STEPS][rsw_pkg::FRAC_BITS-1:0]) *
            QSQ_WIDTH'(quo_ff[rsw_pkg::DIV_STEPS][rsw_pkg::FRAC_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff[0] <= 1'b0;
      end else begin
         hv_ff[0] <= dv_ff[rsw_pkg::DIV_STEPS];
      end
      hc_ff[0].side.mode <= dside_ff[rsw_pkg::DIV_STEPS].mode;
      hc_ff[0].side.kill <= dside_ff[rsw_pkg::DIV_STEPS].kill;
      hc_ff[0].side.lin  <= dside_ff[rsw_pkg::DIV_STEPS].lin;
      hc_ff[0].side.quad <= qsq[QSQ_WIDTH-1:rsw_pkg::FRAC_BITS];
      hc_ff[0].g         <= rsw_pkg::G_WIDTH'(quo_ff[rsw_pkg::DIV_STEPS]) << rsw_pkg::G_SHIFT;
      hs_ff[0]           <= rsw_pkg::S_ONE;
   end

   // ---------------- Horner series for exp(-g), three stages per term ----------------
   localparam int GS_WIDTH = rsw_pkg::G_WIDTH + rsw_pkg::S_WIDTH;
   localparam int T_WIDTH  = rsw_pkg::G_WIDTH + rsw_pkg::RECIP_WIDTH;
   localparam int QK_WIDTH = rsw_pkg::G_WIDTH + 4;

   for (genvar t = 0; t < rsw_pkg::EXP_TERMS; t++) begin : g_term
      localparam int K = rsw_pkg::EXP_TERMS - t;
      localparam logic [rsw_pkg::RECIP_WIDTH-1:0] RECIP =
         rsw_pkg::RECIP_WIDTH'((65'd1 << rsw_pkg::RECIP_SHIFT) / K);

      logic                          a_valid_ff;
      rsw_pkg::carry_type            a_carry_ff;
      logic [GS_WIDTH-1:0]           a_prod_ff;
      logic                          b_valid_ff;
      rsw_pkg::carry_type            b_carry_ff;
      logic [rsw_pkg::G_WIDTH-1:0]   b_v_ff;
      logic [T_WIDTH-1:0]            b_t_ff;
      logic [rsw_pkg::G_WIDTH-1:0]   a_v;
      logic [rsw_pkg::G_WIDTH-1:0]   q0;
      logic [QK_WIDTH-1:0]           rem_k;
      logic [rsw_pkg::G_WIDTH-1:0]   q;

      always_comb begin
         a_v   = a_prod_ff[rsw_pkg::Q31_BITS+rsw_pkg::G_WIDTH-1:rsw_pkg::Q31_BITS];
         q0    = rsw_pkg::G_WIDTH'(b_t_ff >> rsw_pkg::RECIP_SHIFT);
         // reciprocal estimate is low by at most one: fix it up
         rem_k = QK_WIDTH'(b_v_ff) - QK_WIDTH'(q0) * QK_WIDTH'(K);
         q     = (rem_k >= QK_WIDTH'(K)) ? q0 + 1'b1 : q0;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            a_valid_ff <= 1'b0;
            b_valid_ff <= 1'b0;
            hv_ff[t+1] <= 1'b0;
         end else begin
            a_valid_ff <= hv_ff[t];
            b_valid_ff <= a_valid_ff;
            hv_ff[t+1] <= b_valid_ff;
         end
         a_carry_ff <= hc_ff[t];
         a_prod_ff  <= GS_WIDTH'(hc_ff[t].g) * GS_WIDTH'(hs_ff[t]);
         b_carry_ff <= a_carry_ff;
         b_v_ff     <= a_v;
         b_t_ff     <= T_WIDTH'(a_v) * T_WIDTH'(RECIP);
         hc_ff[t+1] <= b_carry_ff;
         hs_ff[t+1] <= rsw_pkg::S_ONE - rsw_pkg::S_WIDTH'(q);
      end
   end

   // ---------------- repeated squaring: exp(-32g) ----------------
   localparam int SQ_WIDTH = 2 * rsw_pkg::S_WIDTH;

   logic               sqv_ff[0:rsw_pkg::EXP_SQUARINGS];
   rsw_pkg::side_type  sqside_ff[0:rsw_pkg::EXP_SQUARINGS];
   rsw_pkg::s_type     sqs_ff[0:rsw_pkg::EXP_SQUARINGS];

   assign sqv_ff[0]    = hv_ff[rsw_pkg::EXP_TERMS];
   assign sqside_ff[0] = hc_ff[rsw_pkg::EXP_TERMS].side;
   assign sqs_ff[0]    = hs_ff[rsw_pkg::EXP_TERMS];

   for (genvar i = 0; i < rsw_pkg::EXP_SQUARINGS; i++) begin : g_square
      logic [SQ_WIDTH-1:0] sq;

      always_comb begin
         sq = SQ_WIDTH'(sqs_ff[i]) * SQ_WIDTH'(sqs_ff[i]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sqv_ff[i+1] <= 1'b0;
         end else begin
            sqv_ff[i+1] <= sqv_ff[i];
         end
         sqside_ff[i+1] <= sqside_ff[i];
         sqs_ff[i+1]    <= rsw_pkg::S_WIDTH'(sq >> rsw_pkg::Q31_BITS);
      end
   end

   // ---------------- output select ----------------
   rsw_pkg::side_type out_side;
   rsw_pkg::data_type weight_in;
   logic              rsp_valid_ff;
   rsw_pkg::data_type rsp_weight_ff;
   rsw_pkg::mode_type rsp_mode_ff;

   always_comb begin
      out_side = sqside_ff[rsw_pkg::EXP_SQUARINGS];
      case (out_side.mode)
         rsw_pkg::MODE_LINEAR:
            weight_in = out_side.lin;
         rsw_pkg::MODE_QUADRATIC:
            weight_in = out_side.kill ? '0 : rsw_pkg::DATA_WIDTH'(out_side.quad);
         rsw_pkg::MODE_EXPONENTIAL:
            weight_in = out_side.kill ? '0 :
               rsw_pkg::DATA_WIDTH'(sqs_ff[rsw_pkg::EXP_SQUARINGS] >>
                                    (rsw_pkg::Q31_BITS - rsw_pkg::FRAC_BITS));
         default:
            weight_in = rsw_pkg::ONE_Q;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sqv_ff[rsw_pkg::EXP_SQUARINGS];
      end
      rsp_weight_ff <= weight_in;
      rsp_mode_ff   <= out_side.mode;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_weight = rsp_weight_ff;

   // ---------------- assertions ----------------
   `ASSERT_IMPLIES(a_result_has_item, clock, reset,
      rsp_valid, $past(start, rsw_pkg::PIPE_LATENCY))
   `ASSERT_IMPLIES(a_weight_unit_bound, clock, reset,
      rsp_valid && (rsp_mode_ff != rsw_pkg::MODE_LINEAR), rsp_weight <= rsw_pkg::ONE_Q)
   `ASSERT_NEXT(a_series_in_range, clock, reset,
      hv_ff[rsw_pkg::EXP_TERMS], sqs_ff[1] <= rsw_pkg::S_ONE)

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the survival weight pipeline: a directed table of
// items, then random items under each weight mode and several limits, with
// every weight compared against a table value or an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int DRAIN_CYCLES = 80;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      rsw_pkg::data_type t;
      rsw_pkg::data_type r;
      logic              known;
      rsw_pkg::data_type w;
   } vector_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   rsw_pkg::data_type                   req_event_time = '0;
   rsw_pkg::data_type                   req_risk_factor = '0;
   logic                                rsp_valid;
   rsw_pkg::data_type                   rsp_weight;
   logic                                csr_write_enable = 1'b0;
   logic [rsw_pkg::CSR_INDEX_WIDTH-1:0] csr_index = rsw_pkg::CSR_WEIGHT_MODE;
   rsw_pkg::data_type                   csr_wdata = '0;

   rsw_pkg::mode_type   cur_mode;
   rsw_pkg::data_type   cur_limit;
   rsw_pkg::data_type   weight_queue[$];
   int                  errors = 0;
   int                  items_sent = 0;
   int                  weights_seen = 0;
   int                  idle_cycles = 0;
   int                  send_idle_pct = 0;

   robust_survival_weight dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_event_time(req_event_time), .req_risk_factor(req_risk_factor),
      .rsp_valid(rsp_valid), .rsp_weight(rsp_weight),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] frac_quotient(logic [63:0] rem, logic [63:0] m);
      logic [63:0] q;
      q = '0;
      for (int i = 0; i < rsw_pkg::FRAC_BITS; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= m) begin
            rem = rem - m;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic rsw_pkg::data_type predict_weight(rsw_pkg::data_type t,
                                                        rsw_pkg::data_type r,
                                                        rsw_pkg::mode_type mode,
                                                        rsw_pkg::data_type lim);
      logic [63:0]  full, p, m, d, q, ip, x, g, s;
      logic [127:0] wide;
      full = 64'(t) * 64'(r);
      p = full >> rsw_pkg::FRAC_BITS;
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      m = 64'(lim);
      case (mode)
         rsw_pkg::MODE_LINEAR: return (m > p) ? rsw_pkg::data_type'(m - p) : '0;
         rsw_pkg::MODE_QUADRATIC: begin
            if (m == 0 || m <= p) return '0;
            d = m - p;
            q = frac_quotient(d, m);
            return rsw_pkg::data_type'((q * q) >> rsw_pkg::FRAC_BITS);
         end
         rsw_pkg::MODE_EXPONENTIAL: begin
            if (m == 0) return '0;
            ip = p / m;
            if (ip >= 32) return '0;
            x = (ip << rsw_pkg::FRAC_BITS) | frac_quotient(p % m, m);
            g = (x << (31 - rsw_pkg::FRAC_BITS)) >> 5;
            s = 64'd1 << 31;
            for (int k = rsw_pkg::EXP_TERMS; k >= 1; k--) begin
               wide = 128'(g) * 128'(s);
               s = (64'd1 << 31) - 64'((wide >> 31) / k);
            end
            for (int i = 0; i < rsw_pkg::EXP_SQUARINGS; i++) s = (s * s) >> 31;
            return rsw_pkg::data_type'(s >> (31 - rsw_pkg::FRAC_BITS));
         end
         default: return rsw_pkg::ONE_Q;
      endcase
   endfunction

   // Check every weight against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         weights_seen <= weights_seen + 1;
         if (weight_queue.size() == 0) begin
            $error("weight: unexpected result, actual %h", rsp_weight);
            errors <= errors + 1;
         end else begin
            if (weight_queue[0] !== rsp_weight) begin
               $error("weight: expected %h actual %h", weight_queue[0], rsp_weight);
               errors <= errors + 1;
            end
            void'(weight_queue.pop_front());
         end
      end
   end

   // Watchdog on cycles with no accepted item, weight, CSR write or reset.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_csr(logic [rsw_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            rsw_pkg::data_type value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == rsw_pkg::CSR_WEIGHT_MODE) cur_mode = rsw_pkg::mode_type'(value[1:0]);
      else cur_limit = value;
   endtask

   // Drop start, then hold until the pipe has drained.
   task automatic drain();
      start <= 1'b0;
      while (weight_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_item(rsw_pkg::data_type t, rsw_pkg::data_type r, logic known,
                            rsw_pkg::data_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_event_time <= t;
      req_risk_factor <= r;
      weight_queue.push_back(known ? w : predict_weight(t, r, cur_mode, cur_limit));
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   function automatic rsw_pkg::data_type rand_field();
      case ($urandom_range(3))
         0: return rsw_pkg::data_type'($urandom_range(4 * 65536));
         1: return rsw_pkg::data_type'($urandom) >> $urandom_range(31);
         2: return rsw_pkg::data_type'($urandom);
         default: return rsw_pkg::data_type'($urandom_range(65536 * 16, 0));
      endcase
   endfunction

   vector_type          table_rows[$];
   rsw_pkg::data_type   limits[6];

   initial begin
      limits = '{32'd1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_8000, 32'h0010_0000, 32'd0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      cur_mode = rsw_pkg::MODE_IDENTITY;
      cur_limit = rsw_pkg::LIMIT_M_RESET;

      // Directed rows: reset settings first, then each mode at its extremes.
      table_rows.push_back('{32'h0, 32'h0, 1'b1, rsw_pkg::ONE_Q});
      table_rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, rsw_pkg::ONE_Q});
      foreach (table_rows[i]) send_item(table_rows[i].t, table_rows[i].r, table_rows[i].known,
                                        table_rows[i].w);
      drain();
      for (int md = 1; md < 4; md++) begin
         write_csr(rsw_pkg::CSR_WEIGHT_MODE, rsw_pkg::data_type'(md));
         write_csr(rsw_pkg::CSR_LIMIT_M, rsw_pkg::ONE_Q);
         table_rows.delete();
         table_rows.push_back('{32'h0, 32'h0, md == 1, rsw_pkg::ONE_Q});
         table_rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0});
         table_rows.push_back('{32'h0001_0000, 32'h0000_8000, 1'b0, '0});
         table_rows.push_back('{32'h0001_0000, 32'h0001_0000, 1'b0, '0});
         table_rows.push_back('{32'h0020_0000, 32'h0001_0000, 1'b0, '0});
         table_rows.push_back('{32'h001F_FFFF, 32'h0001_0000, 1'b0, '0});
         foreach (table_rows[i]) send_item(table_rows[i].t, table_rows[i].r, table_rows[i].known,
                                           table_rows[i].w);
         drain();
      end
      // Limit zero gives weight 0 outside identity.
      write_csr(rsw_pkg::CSR_LIMIT_M, '0);
      send_item(32'h0001_0000, 32'h0001_0000, 1'b1, '0);
      drain();

      // Random phases over modes, limits and idling profiles.
      for (int ph = 0; ph < 24; ph++) begin
         send_idle_pct = (ph < 8) ? 17 : (ph < 16) ? 63 : 0;
         write_csr(rsw_pkg::CSR_WEIGHT_MODE, rsw_pkg::data_type'(ph % 4));
         write_csr(rsw_pkg::CSR_LIMIT_M, (ph % 3 == 0) ? limits[(ph / 3) % 6] : rand_field());
         for (int n = 0; n < 17; n++) send_item(rand_field(), rand_field(), 1'b0, '0);
         drain();
      end
      drain();

      $display("Sent %0d items over four weight modes and %0d checked weights.",
               items_sent, weights_seen);
      if (errors == 0 && weight_queue.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
